// ===== rtl/bfla_pkg.sv =====
`timescale 1ns / 1ps
package bfla_pkg;

    localparam int DEF_MAX_BLOCKS = 1024;

    localparam int CMD_W   = 1;
    localparam int INDEX_W = 16;
    localparam int STAT_W  = 2;
    localparam int GRANT_W = 10;
    localparam int COUNT_W = 11;

    localparam logic [COUNT_W-1:0] RESET_BLOCK_COUNT = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_DOUBLE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

// ===== rtl/block_free_list_allocator_unit.sv =====
`timescale 1ns / 1ps
// An accepted transaction enters the execute state, and its result is registered into the
// output register when it leaves; it waits there while an earlier result is held under stall.
// A new transaction is not accepted until the previous one is written back, as the stack
// and free-flag memories are read at acceptance and written back in the execute state.
// Reset (synchronous, active low) and every block-count write refill the pool at once:
// a low-water mark stands in for the memory contents, so there is no clearing pass.
module block_free_list_allocator_unit #(
    parameter int MAX_BLOCKS = bfla_pkg::DEF_MAX_BLOCKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfla_pkg::COUNT_W-1:0]  i_cfg_block_count,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bfla_pkg::CMD_W-1:0]    i_cmd,
    input  logic [bfla_pkg::INDEX_W-1:0]  i_block_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bfla_pkg::STAT_W-1:0]   o_status,
    output logic [bfla_pkg::GRANT_W-1:0]  o_granted_block,
    output logic [bfla_pkg::COUNT_W-1:0]  o_free_count
);
    import bfla_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] RESET_POOL =
        (int'(RESET_BLOCK_COUNT) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(RESET_BLOCK_COUNT);

    t_state                 r_state;
    logic [CW-1:0]          r_pool;
    logic [CW-1:0]          r_depth;
    logic [CW-1:0]          r_low;
    logic [CMD_W-1:0]       r_cmd;
    logic [INDEX_W-1:0]     r_idx;
    logic [AW-1:0]          r_pos;
    logic                   r_out_valid;
    t_status                r_status;
    logic [GRANT_W-1:0]     r_grant;
    logic [COUNT_W-1:0]     r_count;

    logic [CW-1:0]          n_depth;
    logic [CW-1:0]          n_low;
    t_status                n_status;
    logic [GRANT_W-1:0]     n_grant;
    logic [CW-1:0]          n_pool;

    logic                   in_accept;
    logic                   cfg_accept;
    logic                   done;
    logic [AW-1:0]          stack_rd_addr;
    logic [AW-1:0]          stack_rd_data;
    logic [AW-1:0]          top_block;
    logic                   flag_rd_data;
    logic                   idx_free;
    logic                   stack_wr_en;
    logic                   flag_wr_en;
    logic [AW-1:0]          flag_wr_addr;
    logic                   flag_wr_data;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;
    assign done        = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    assign stack_rd_addr = AW'(r_depth - CW'(1));
    assign n_pool = (32'(i_cfg_block_count) > 32'(MAX_BLOCKS)) ?
                    CW'(MAX_BLOCKS) : CW'(i_cfg_block_count);

    bfla_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_BLOCKS)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stack_wr_en),
        .i_wr_addr (AW'(r_depth)),
        .i_wr_data (AW'(r_idx)),
        .i_rd_en   (in_accept),
        .i_rd_addr (stack_rd_addr),
        .o_rd_data (stack_rd_data)
    );

    bfla_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_flag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (flag_wr_en),
        .i_wr_addr (flag_wr_addr),
        .i_wr_data (flag_wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (AW'(i_block_index)),
        .o_rd_data (flag_rd_data)
    );

    // Positions below the low-water mark still hold their refill value.
    assign top_block = (CW'(r_pos) < r_low) ? AW'(r_pool - CW'(1) - CW'(r_pos)) :
                       stack_rd_data;
    // Blocks never popped since the refill are still free.
    assign idx_free = (32'(r_idx) >= 32'(r_pool - r_low)) ? 1'b1 : flag_rd_data;

    always_comb begin
        n_depth      = r_depth;
        n_low        = r_low;
        n_status     = ST_OK;
        n_grant      = '0;
        stack_wr_en  = 1'b0;
        flag_wr_en   = 1'b0;
        flag_wr_addr = top_block;
        flag_wr_data = 1'b0;
        if (r_cmd == CMD_ALLOC) begin
            if (r_depth == '0) begin
                n_status = ST_FULL;
            end else begin
                n_depth    = r_depth - CW'(1);
                n_low      = (n_depth < r_low) ? n_depth : r_low;
                n_grant    = GRANT_W'(top_block);
                flag_wr_en = done;
            end
        end else begin
            flag_wr_addr = AW'(r_idx);
            flag_wr_data = 1'b1;
            if (32'(r_idx) >= 32'(r_pool)) begin
                n_status = ST_RANGE;
            end else if (idx_free) begin
                n_status = ST_DOUBLE;
            end else begin
                n_depth     = r_depth + CW'(1);
                stack_wr_en = done;
                flag_wr_en  = done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pool      <= RESET_POOL;
            r_depth     <= RESET_POOL;
            r_low       <= RESET_POOL;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (cfg_accept) begin
                        r_pool  <= n_pool;
                        r_depth <= n_pool;
                        r_low   <= n_pool;
                    end
                    if (in_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (done) begin
                        r_depth <= n_depth;
                        r_low   <= n_low;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_cmd;
            r_idx <= i_block_index;
            r_pos <= stack_rd_addr;
        end
        if (done) begin
            r_status <= n_status;
            r_grant  <= n_grant;
            r_count  <= COUNT_W'(n_depth);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_block = r_grant;
    assign o_free_count    = r_count;

`ifndef SYNTHESIS
    a_depth_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_pool)
        else $error("stack depth exceeds pool size");

    a_low_below_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_depth)
        else $error("low-water mark above stack depth");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not start");

    a_full_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_free_count == '0))
        else $error("pool full reported with free blocks");
`endif

endmodule

// ===== rtl/bfla_ram.sv =====
`timescale 1ns / 1ps
module bfla_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
